/* hw/rtl/incircle_test_unit_defines.svh */
// Assertion macros for the in-circle test unit checker.
// Depends on nothing; the including module provides clk and rst.
`ifndef INCIRCLE_TEST_UNIT_DEFINES_SVH
`define INCIRCLE_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define INCT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define INCT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);

`endif

/* hw/rtl/inct_pkg.sv */
// Shared types and constants of the in-circle test unit.
// Depends on nothing; used by the top level and its checker.
package inct_pkg;

  localparam int CoordWidth = 16;
  localparam int Latency = 7;

  typedef struct packed {
    logic signed [CoordWidth-1:0] ax;
    logic signed [CoordWidth-1:0] ay;
    logic signed [CoordWidth-1:0] bx;
    logic signed [CoordWidth-1:0] by;
    logic signed [CoordWidth-1:0] cx;
    logic signed [CoordWidth-1:0] cy;
    logic signed [CoordWidth-1:0] qx;
    logic signed [CoordWidth-1:0] qy;
  } coords_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } result_t;

endpackage

/* hw/rtl/incircle_test_unit.sv */
// Top level of the in-circle test unit: exact Delaunay in-circle predicate.
// Depends on inct_pkg for the beat types and the coordinate width.
//
// Each beat on coords carries a triangle a, b, c and a query point q; the unit
// answers whether q lies inside or on the circumcircle, with collinear vertices
// flagged as degenerate. A beat is taken at every clock edge where start is high,
// and busy never rises, so one test can be issued in every cycle. The answer
// appears on result with done high for exactly one cycle, once the beat has
// passed through all register stages; the receiver cannot hold it off. The
// pipeline has seven register stages: coordinate differences, coordinate
// products, lifts, cross terms and orientation, split partial products of the
// lift-by-cross multiply, recombination of those products, the determinant sum,
// and the final sign decision. All arithmetic is exact integer math.
module incircle_test_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  inct_pkg::coords_t coords,
  output logic              done,
  output inct_pkg::result_t result
);

  localparam int W = inct_pkg::CoordWidth;
  localparam int D = W + 1;
  localparam int P = 2 * W + 1;
  localparam int C = 2 * W + 2;
  localparam int H = W + 1;
  localparam int T = 4 * W + 5;

  logic accept;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [D-1:0] dx [3];
  logic signed [D-1:0] dy [3];
  logic signed [D-1:0] oe1, oe2, oe3, oe4;

  logic signed [P-1:0] sqx [3];
  logic signed [P-1:0] sqy [3];
  logic signed [P-1:0] pm [3];
  logic signed [P-1:0] pn [3];
  logic signed [P-1:0] op1, op2;

  logic        [P-1:0] lift [3];
  logic signed [C-1:0] xterm [3];
  logic signed [C-1:0] orient;

  logic        [2*H-1:0] pp_ll [3];
  logic signed [2*W+2:0] pp_lh [3];
  logic        [2*W:0]   pp_hl [3];
  logic signed [2*W+1:0] pp_hh [3];
  logic o4_zero, o4_neg;

  logic signed [T-1:0] term [3];
  logic o5_zero, o5_neg;

  logic signed [T-1:0] det;
  logic o6_zero, o6_neg;

  logic det_zero, det_neg;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    dx[0] <= D'(coords.ax) - D'(coords.qx);
    dy[0] <= D'(coords.ay) - D'(coords.qy);
    dx[1] <= D'(coords.bx) - D'(coords.qx);
    dy[1] <= D'(coords.by) - D'(coords.qy);
    dx[2] <= D'(coords.cx) - D'(coords.qx);
    dy[2] <= D'(coords.cy) - D'(coords.qy);
    oe1   <= D'(coords.bx) - D'(coords.ax);
    oe2   <= D'(coords.cy) - D'(coords.ay);
    oe3   <= D'(coords.by) - D'(coords.ay);
    oe4   <= D'(coords.cx) - D'(coords.ax);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sqx[k] <= dx[k] * dx[k];
      sqy[k] <= dy[k] * dy[k];
    end
    pm[0] <= dx[1] * dy[2];
    pn[0] <= dx[2] * dy[1];
    pm[1] <= dx[2] * dy[0];
    pn[1] <= dx[0] * dy[2];
    pm[2] <= dx[0] * dy[1];
    pn[2] <= dx[1] * dy[0];
    op1   <= oe1 * oe2;
    op2   <= oe3 * oe4;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lift[k]  <= $unsigned(sqx[k] + sqy[k]);
      xterm[k] <= C'(pm[k]) - C'(pn[k]);
    end
    orient <= C'(op1) - C'(op2);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pp_ll[k] <= lift[k][H-1:0] * $unsigned(xterm[k][H-1:0]);
      pp_lh[k] <= $signed({1'b0, lift[k][H-1:0]}) * $signed(xterm[k][C-1:H]);
      pp_hl[k] <= lift[k][P-1:H] * $unsigned(xterm[k][H-1:0]);
      pp_hh[k] <= $signed({1'b0, lift[k][P-1:H]}) * $signed(xterm[k][C-1:H]);
    end
    o4_zero <= (orient == '0);
    o4_neg  <= orient[C-1];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      term[k] <= $signed(T'(pp_ll[k]))
               + ((T'(pp_lh[k]) + $signed(T'(pp_hl[k]))) <<< H)
               + (T'(pp_hh[k]) <<< (2 * H));
    end
    o5_zero <= o4_zero;
    o5_neg  <= o4_neg;
  end

  always_ff @(posedge clk) begin
    det     <= term[0] + term[1] + term[2];
    o6_zero <= o5_zero;
    o6_neg  <= o5_neg;
  end

  assign det_zero = (det == '0);
  assign det_neg  = det[T-1];

  always_ff @(posedge clk) begin
    result.degenerate <= o6_zero;
    result.inside_res <= !o6_zero && (det_zero || (det_neg == o6_neg));
  end

endmodule

/* hw/rtl/inct_checker.sv */
// Port-level checker for the in-circle test unit, bound to the top level.
// Depends on inct_pkg and the assertion macros in incircle_test_unit_defines.svh.
`include "incircle_test_unit_defines.svh"

module inct_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input inct_pkg::coords_t coords,
  input logic              done,
  input inct_pkg::result_t result
);

  `INCT_ASSERT_NXT(a_busy_low, 1'b1, !busy, "busy rose on a unit that never stalls")
  `INCT_ASSERT_IMP(a_done_src, done, $past(start, inct_pkg::Latency), "result without a beat")
  `INCT_ASSERT_IMP(a_done_lat, start, ##(inct_pkg::Latency) done, "beat produced no result")
  `INCT_ASSERT_IMP(a_coincident, start && coords.ax == coords.bx && coords.ay == coords.by, ##(inct_pkg::Latency) (done && result.degenerate && !result.inside_res), "coincident vertices not flagged")

endmodule

bind incircle_test_unit inct_checker u_inct_checker (.*);
